>>> rtl/fat_dir_entry_parser_top_assert.svh
// ---------------------------------------------------------------------------
// fat directory entry parser assertion macros
// clocked, reset-qualified assertion wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef FAT_DIR_ENTRY_PARSER_TOP_ASSERT_SVH
`define FAT_DIR_ENTRY_PARSER_TOP_ASSERT_SVH

// property that holds at every edge outside reset
`define FDEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define FDEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fdep_pkg.sv
// ---------------------------------------------------------------------------
// fdep_pkg
// shared types and constants of the fat directory entry parser
// ---------------------------------------------------------------------------
package fdep_pkg;

  localparam int NAME_CHARS = 12;

  // entry byte positions
  localparam logic [4:0] POS_EXT      = 5'd8;
  localparam logic [4:0] POS_EXT_LAST = 5'd10;
  localparam logic [4:0] POS_ATTR     = 5'd11;
  localparam logic [4:0] POS_CLUS_HI0 = 5'd20;
  localparam logic [4:0] POS_CLUS_HI1 = 5'd21;
  localparam logic [4:0] POS_CLUS_LO0 = 5'd26;
  localparam logic [4:0] POS_CLUS_LO1 = 5'd27;
  localparam logic [4:0] POS_SIZE0    = 5'd28;
  localparam logic [4:0] POS_LAST     = 5'd31;

  // byte codes
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam int         ATTR_VOL_BIT = 3;
  localparam int         ATTR_DIR_BIT = 4;

  typedef logic [NAME_CHARS-1:0][7:0] name_buf_t;

  typedef struct packed {
    logic        end_of_listing;
    logic        is_directory;
    logic [63:0] name_low;
    logic [31:0] name_high;
    logic [3:0]  name_length;
    logic [31:0] entry_size;
    logic [31:0] first_cluster;
  } result_t;

endpackage

>>> rtl/fdep_entry_asm.sv
// ---------------------------------------------------------------------------
// fdep_entry_asm
// input word register and per-byte entry assembly into one result
// ---------------------------------------------------------------------------
module fdep_entry_asm import fdep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_listing_i,
  input  logic       room_i,
  output logic       push_o,
  output result_t    res_o
);

  logic        vld_q;
  logic [7:0]  byte_q;
  logic        start_q;

  logic [4:0]  pos_q, pos_d;
  logic        ended_q, ended_d;
  logic        skip_q, skip_d;
  name_buf_t   name_q, name_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        dot_q, dot_d;
  logic [7:0]  attr_q, attr_d;
  logic [31:0] clus_q, clus_d;
  logic [31:0] size_q, size_d;

  logic fire;
  logic blank;
  logic [4:0] p;

  assign fire       = vld_q & room_i;
  assign in_ready_o = ~vld_q | room_i;
  assign blank      = (byte_q == CHAR_SPACE) || (byte_q == CHAR_NUL);
  assign p          = start_q ? 5'd0 : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= data_byte_i;
      start_q <= start_listing_i;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    ended_d = ended_q;
    skip_d  = skip_q;
    name_d  = name_q;
    cnt_d   = cnt_q;
    dot_d   = dot_q;
    attr_d  = attr_q;
    clus_d  = clus_q;
    size_d  = size_q;
    push_o  = 1'b0;
    res_o   = '0;
    if (fire) begin
      if (start_q) begin
        ended_d = 1'b0;
        pos_d   = 5'd0;
      end
      if (start_q || !ended_q) begin
        if (p == 5'd0) begin
          name_d = '0;
          cnt_d  = 4'd0;
          dot_d  = 1'b0;
          attr_d = 8'd0;
          clus_d = 32'd0;
          size_d = 32'd0;
          skip_d = 1'b0;
        end
        if (p == 5'd0 && byte_q == CHAR_NUL) begin
          // end marker entry
          ended_d              = 1'b1;
          pos_d                = 5'd0;
          push_o               = 1'b1;
          res_o.end_of_listing = 1'b1;
        end else begin
          if (p == 5'd0 && byte_q == DELETED_MARK) begin
            skip_d = 1'b1;
          end
          priority if (p < POS_EXT) begin
            if (!blank && cnt_d < 4'(NAME_CHARS)) begin
              name_d[cnt_d] = byte_q;
              cnt_d         = cnt_d + 4'd1;
            end
          end else if (p == POS_EXT) begin
            if (!blank) begin
              if (cnt_d < 4'(NAME_CHARS)) begin
                name_d[cnt_d] = CHAR_DOT;
                cnt_d         = cnt_d + 4'd1;
              end
              if (cnt_d < 4'(NAME_CHARS)) begin
                name_d[cnt_d] = byte_q;
                cnt_d         = cnt_d + 4'd1;
              end
              dot_d = 1'b1;
            end
          end else if (p <= POS_EXT_LAST) begin
            if (dot_d && !blank && cnt_d < 4'(NAME_CHARS)) begin
              name_d[cnt_d] = byte_q;
              cnt_d         = cnt_d + 4'd1;
            end
          end else if (p == POS_ATTR) begin
            attr_d = byte_q;
            if (byte_q == ATTR_LFN || byte_q[ATTR_VOL_BIT]) begin
              skip_d = 1'b1;
            end
          end else if (p == POS_CLUS_HI0) begin
            clus_d[23:16] = clus_d[23:16] | byte_q;
          end else if (p == POS_CLUS_HI1) begin
            clus_d[31:24] = clus_d[31:24] | byte_q;
          end else if (p == POS_CLUS_LO0) begin
            clus_d[7:0] = clus_d[7:0] | byte_q;
          end else if (p == POS_CLUS_LO1) begin
            clus_d[15:8] = clus_d[15:8] | byte_q;
          end else if (p >= POS_SIZE0) begin
            size_d[{p[1:0], 3'b000} +: 8] = size_d[{p[1:0], 3'b000} +: 8] | byte_q;
          end else begin
            // reserved and time fields carry nothing
          end
          pos_d = p + 5'd1;
          if (p == POS_LAST && !skip_d) begin
            push_o              = 1'b1;
            res_o.is_directory  = attr_d[ATTR_DIR_BIT];
            res_o.name_low      = name_d[7:0];
            res_o.name_high     = name_d[NAME_CHARS-1:8];
            res_o.name_length   = cnt_d;
            res_o.entry_size    = size_d;
            res_o.first_cluster = clus_d;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 5'd0;
      ended_q <= 1'b0;
      skip_q  <= 1'b0;
      name_q  <= '0;
      cnt_q   <= 4'd0;
      dot_q   <= 1'b0;
      attr_q  <= 8'd0;
      clus_q  <= 32'd0;
      size_q  <= 32'd0;
    end else begin
      pos_q   <= pos_d;
      ended_q <= ended_d;
      skip_q  <= skip_d;
      name_q  <= name_d;
      cnt_q   <= cnt_d;
      dot_q   <= dot_d;
      attr_q  <= attr_d;
      clus_q  <= clus_d;
      size_q  <= size_d;
    end
  end

endmodule

>>> rtl/fdep_res_fifo.sv
// ---------------------------------------------------------------------------
// fdep_res_fifo
// two-word result buffer between the assembler and the output channel
// ---------------------------------------------------------------------------
module fdep_res_fifo import fdep_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign room_o      = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i;
    end
  end

  // head register: the other slot when a full buffer pops, the incoming word when it pops otherwise or is empty
  always_ff @(posedge clk_i) begin
    if (pop && cnt_q == 2'd2) begin
      res_o <= mem_q[~rd_q];
    end else if (pop || cnt_q == 2'd0) begin
      res_o <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/fat_dir_entry_parser_top.sv
// ---------------------------------------------------------------------------
// fat_dir_entry_parser_top
// fat directory listing parser: bytes in, one word per visible entry out
// ---------------------------------------------------------------------------
// usage
//   input channel: one directory byte per word (data_byte_i) with
//   start_listing_i marking the first byte of a new listing
//   output channel: one word per file or directory entry, or one word
//   with end_of_listing_o set for the zero end marker, other fields zero
//   deleted, long-name and volume-label entries give no word
// result path
//   the result word for byte 31 of an entry (or byte 0 of the end marker)
//   passes the input register, then the result buffer to its head register;
//   it waits in the input register while that buffer is full
// throughput
//   one byte per cycle while the buffer has room; set by the single pass
//   through the entry assembler between its input register and result buffer
// reset
//   clears byte position and listing state; output buffer empty
// stall
//   a two-word result buffer keeps ready high while one result waits;
//   ready drops only when both buffer slots and the input register hold
// ---------------------------------------------------------------------------
module fat_dir_entry_parser_top import fdep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_listing_i,
  // entry words out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        end_of_listing_o,
  output logic        is_directory_o,
  output logic [63:0] name_low_o,
  output logic [31:0] name_high_o,
  output logic [3:0]  name_length_o,
  output logic [31:0] entry_size_o,
  output logic [31:0] first_cluster_o
);

  logic    room;
  logic    push;
  result_t asm_res;
  result_t out_res;

  // per-byte entry assembly with its own input register
  fdep_entry_asm u_asm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .start_listing_i (start_listing_i),
    .room_i          (room),
    .push_o          (push),
    .res_o           (asm_res)
  );

  // result buffer decouples a stalled receiver from the byte stream
  fdep_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (asm_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign end_of_listing_o = out_res.end_of_listing;
  assign is_directory_o   = out_res.is_directory;
  assign name_low_o       = out_res.name_low;
  assign name_high_o      = out_res.name_high;
  assign name_length_o    = out_res.name_length;
  assign entry_size_o     = out_res.entry_size;
  assign first_cluster_o  = out_res.first_cluster;

endmodule

>>> rtl/fdep_checker.sv
// ---------------------------------------------------------------------------
// fdep_checker
// port-level checks of the fat directory entry parser
// ---------------------------------------------------------------------------
`include "fat_dir_entry_parser_top_assert.svh"

module fdep_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        end_of_listing_o,
  input logic        is_directory_o,
  input logic [63:0] name_low_o,
  input logic [31:0] name_high_o,
  input logic [3:0]  name_length_o,
  input logic [31:0] entry_size_o,
  input logic [31:0] first_cluster_o
);

  logic         stalled;
  logic         end_seen;
  logic         short_name;
  logic [164:0] out_rest;
  logic [165:0] out_word;

  assign stalled    = out_valid_o && !out_ready_i;
  assign end_seen   = out_valid_o && end_of_listing_o;
  assign short_name = out_valid_o && (name_length_o <= 4'd8);
  assign out_rest   = {is_directory_o, name_low_o, name_high_o, name_length_o, entry_size_o,
                       first_cluster_o};
  assign out_word   = {end_of_listing_o, out_rest};

  // a stalled word holds
  `FDEP_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(out_word), "word changed while stalled")

  // end marker word carries nothing else
  `FDEP_ASSERT(a_end_clean, !end_seen || out_rest == '0, "end word has nonzero fields")

  // compacted name never longer than twelve characters
  `FDEP_ASSERT(a_len_max, !out_valid_o || name_length_o <= 4'd12, "name length above twelve")

  // upper name word is empty for short names
  `FDEP_ASSERT(a_high_empty, !short_name || name_high_o == 32'd0, "name characters beyond length")

  // handshake outputs always known out of reset
  `FDEP_ASSERT(a_hs_known, !$isunknown({in_ready_o, out_valid_o}), "handshake output unknown")

endmodule

bind fat_dir_entry_parser_top fdep_checker u_fdep_checker (.*);

>>> verif/fat_dir_entry_parser_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat_dir_entry_parser_top_tb
// self-checking bench: feeds fat directory listings byte by byte, predicts
// each entry word in a scoreboard and compares it field by field
// ---------------------------------------------------------------------------
module fat_dir_entry_parser_top_tb import fdep_pkg::*; ();

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 1300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  // shadow of the parser: follows every accepted byte and queues the word
  // that the block has to produce for it
  class entry_scoreboard;
    logic [4:0]  pos;
    bit          ended;
    bit          skipped;
    bit          dot_seen;
    name_buf_t   name_buf;
    logic [3:0]  name_cnt;
    logic [7:0]  attr;
    logic [31:0] clus_acc;
    logic [31:0] size_acc;
    result_t     pending[$];
    int          errors;
    int          file_words;
    int          end_words;

    function new();
      pos = '0;
      ended = 0;
      errors = 0;
      file_words = 0;
      end_words = 0;
      clear_entry();
    endfunction

    function void clear_entry();
      skipped = 0;
      dot_seen = 0;
      name_buf = '0;
      name_cnt = '0;
      attr = '0;
      clus_acc = '0;
      size_acc = '0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NUL);
    endfunction

    function void add_char(logic [7:0] c);
      if (name_cnt < NAME_CHARS) begin
        name_buf[name_cnt] = c;
        name_cnt++;
      end
    endfunction

    function void note_byte(logic [7:0] b, bit st);
      result_t    w;
      logic [4:0] p;
      if (st) begin
        ended = 0;
        pos = '0;
      end
      if (ended) return;
      p = pos;
      if (p == 5'd0) begin
        clear_entry();
        if (b == CHAR_NUL) begin
          // end marker: flag only, everything else zero
          ended = 1;
          pos = '0;
          w = '0;
          w.end_of_listing = 1'b1;
          pending.push_back(w);
          return;
        end
        if (b == DELETED_MARK) skipped = 1;
      end
      if (p < POS_EXT) begin
        if (!is_blank(b)) add_char(b);
      end else if (p == POS_EXT) begin
        if (!is_blank(b)) begin
          add_char(CHAR_DOT);
          add_char(b);
          dot_seen = 1;
        end
      end else if (p <= POS_EXT_LAST) begin
        if (dot_seen && !is_blank(b)) add_char(b);
      end else if (p == POS_ATTR) begin
        attr = b;
        if (b == ATTR_LFN || b[ATTR_VOL_BIT]) skipped = 1;
      end else if (p == POS_CLUS_HI0) begin
        clus_acc[23:16] = b;
      end else if (p == POS_CLUS_HI1) begin
        clus_acc[31:24] = b;
      end else if (p == POS_CLUS_LO0) begin
        clus_acc[7:0] = b;
      end else if (p == POS_CLUS_LO1) begin
        clus_acc[15:8] = b;
      end else if (p >= POS_SIZE0) begin
        size_acc[(p - POS_SIZE0) * 8 +: 8] = b;
      end
      pos = p + 5'd1;
      if (p != POS_LAST || skipped) return;
      w.end_of_listing = 1'b0;
      w.is_directory = attr[ATTR_DIR_BIT];
      w.name_low = name_buf[7:0];
      w.name_high = name_buf[11:8];
      w.name_length = name_cnt;
      w.entry_size = size_acc;
      w.first_cluster = clus_acc;
      pending.push_back(w);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("word with nothing pending, end flag", 64'(got.end_of_listing), 64'd0);
        return;
      end
      want = pending.pop_front();
      if (want.end_of_listing) end_words++;
      else file_words++;
      if (got.end_of_listing !== want.end_of_listing)
        report("end_of_listing", 64'(got.end_of_listing), 64'(want.end_of_listing));
      if (got.is_directory !== want.is_directory)
        report("is_directory", 64'(got.is_directory), 64'(want.is_directory));
      if (got.name_low !== want.name_low)
        report("name_low", got.name_low, want.name_low);
      if (got.name_high !== want.name_high)
        report("name_high", 64'(got.name_high), 64'(want.name_high));
      if (got.name_length !== want.name_length)
        report("name_length", 64'(got.name_length), 64'(want.name_length));
      if (got.entry_size !== want.entry_size)
        report("entry_size", 64'(got.entry_size), 64'(want.entry_size));
      if (got.first_cluster !== want.first_cluster)
        report("first_cluster", 64'(got.first_cluster), 64'(want.first_cluster));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        start_listing_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        end_of_listing_o;
  logic        is_directory_o;
  logic [63:0] name_low_o;
  logic [31:0] name_high_o;
  logic [3:0]  name_length_o;
  logic [31:0] entry_size_o;
  logic [31:0] first_cluster_o;

  entry_scoreboard sb;

  // one directory entry under construction, sent in disk order
  logic [7:0] entry_bytes [32];

  int  cycles;
  int  bytes_sent;
  int  hold_req;
  int  hold_done;
  // no random idle gaps on either side while set
  bit  quiet;

  fat_dir_entry_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .start_listing_i (start_listing_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .end_of_listing_o(end_of_listing_o),
    .is_directory_o  (is_directory_o),
    .name_low_o      (name_low_o),
    .name_high_o     (name_high_o),
    .name_length_o   (name_length_o),
    .entry_size_o    (entry_size_o),
    .first_cluster_o (first_cluster_o)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then a long one
  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // output side: random ready pattern, plus long hold-offs on request so
  // the result buffer fills and the input gets back-pressured
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_done < hold_req) begin
        hold_done++;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        int gap;
        gap = pick_gap();
        repeat (gap) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
        @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // every accepted output word goes to the scoreboard
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.end_of_listing = end_of_listing_o;
      got.is_directory = is_directory_o;
      got.name_low = name_low_o;
      got.name_high = name_high_o;
      got.name_length = name_length_o;
      got.entry_size = entry_size_o;
      got.first_cluster = first_cluster_o;
      sb.check_word(got);
    end
  end

  // one byte word: optional idle gap, then hold valid until accepted
  task send_byte(logic [7:0] b, bit st);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    start_listing_i <= st;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, st);
    bytes_sent++;
  endtask

  // first count bytes of the entry; fewer than 32 leaves it cut short
  task send_entry(bit first_start, int count);
    for (int i = 0; i < count; i++)
      send_byte(entry_bytes[i], (i == 0) ? first_start : 1'b0);
  endtask

  function void set_name(string s);
    for (int i = 0; i < 11; i++) entry_bytes[i] = s[i];
  endfunction

  // attribute, cluster and size; unused bytes get random filler
  function void fill_fields(logic [7:0] at, logic [31:0] cl, logic [31:0] sz);
    for (int i = 12; i < 32; i++) entry_bytes[i] = 8'($urandom_range(0, 255));
    entry_bytes[POS_ATTR] = at;
    entry_bytes[POS_CLUS_HI0] = cl[23:16];
    entry_bytes[POS_CLUS_HI1] = cl[31:24];
    entry_bytes[POS_CLUS_LO0] = cl[7:0];
    entry_bytes[POS_CLUS_LO1] = cl[15:8];
    for (int k = 0; k < 4; k++) entry_bytes[POS_SIZE0 + k] = sz[8 * k +: 8];
  endfunction

  function logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'(8'h41 + $urandom_range(0, 25));
    if (r < 60) return 8'(8'h30 + $urandom_range(0, 9));
    if (r < 75) return CHAR_SPACE;
    if (r < 82) return CHAR_NUL;
    return 8'($urandom_range(1, 255));
  endfunction

  function logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 20) return 32'hFFFF_FFFF;
    if (r < 40) return $urandom_range(0, 65535);
    return $urandom;
  endfunction

  // a visible entry: random 8.3 name, attribute without the volume bit
  function void random_file();
    logic [7:0] at;
    for (int i = 0; i < 11; i++) entry_bytes[i] = rand_char();
    if (entry_bytes[0] == CHAR_NUL || entry_bytes[0] == DELETED_MARK)
      entry_bytes[0] = "X";
    at = 8'($urandom_range(0, 255));
    at[ATTR_VOL_BIT] = 1'b0;
    fill_fields(at, rand_word(), rand_word());
  endfunction

  function void end_marker();
    for (int i = 0; i < 32; i++) entry_bytes[i] = 8'($urandom_range(0, 255));
    entry_bytes[0] = CHAR_NUL;
  endfunction

  initial begin
    int  n;
    int  kind;
    int  rand_start;
    bit  need_start;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    start_listing_i = 1'b0;
    cycles = 0;
    bytes_sent = 0;
    hold_req = 0;
    hold_done = 0;
    quiet = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed listing ----
    // plain file with extension
    set_name("README  TXT");
    fill_fields(8'h20, 32'h0001_0002, 32'h0000_1234);
    send_entry(1, 32);
    // full twelve-character name, all-ones size and cluster
    set_name("ABCDEFGHIJK");
    fill_fields(8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_entry(0, 32);
    // directory, no extension, zero size and cluster
    set_name("DOCS       ");
    fill_fields(8'h10, 32'h0, 32'h0);
    send_entry(0, 32);
    // all blanks gives an empty name
    set_name("           ");
    fill_fields(8'h01, 32'h0000_0003, 32'h0000_0001);
    send_entry(0, 32);
    // extension starting blank is dropped even with later characters
    set_name("A B      XY");
    fill_fields(8'h20, 32'h1234_5678, 32'h8765_4321);
    send_entry(0, 32);
    // zeros inside name and extension are squeezed out, directory bit set
    set_name("F       T Z");
    entry_bytes[1] = CHAR_NUL;
    entry_bytes[9] = CHAR_NUL;
    fill_fields(8'hF7, 32'hABCD_0000, 32'h0000_FFFF);
    send_entry(0, 32);
    // deleted entry
    set_name("ZZZ     DAT");
    entry_bytes[0] = DELETED_MARK;
    fill_fields(8'h20, 32'h5, 32'h6);
    send_entry(0, 32);
    // long-name entry
    set_name("LONGNAMEPRT");
    fill_fields(ATTR_LFN, 32'h0, 32'hFFFF_FFFF);
    send_entry(0, 32);
    // volume label, then an attribute of all ones
    set_name("VOLUME  LBL");
    fill_fields(8'h08, 32'h7, 32'h8);
    send_entry(0, 32);
    set_name("ALLONES ATR");
    fill_fields(8'hFF, 32'h9, 32'hA);
    send_entry(0, 32);
    // entry cut short by a new listing start
    set_name("PART    BIN");
    fill_fields(8'h20, 32'h11, 32'h22);
    send_entry(0, 10);
    set_name("NEXT    BIN");
    fill_fields(8'h20, 32'h33, 32'h44);
    send_entry(1, 32);
    // end marker, then bytes that the block must ignore
    end_marker();
    send_entry(0, 32);
    repeat (5) send_byte(8'($urandom_range(0, 255)), 1'b0);
    // new listing whose very first byte is an end marker
    send_byte(CHAR_NUL, 1'b1);

    // ---- random listings ----
    rand_start = bytes_sent;
    for (int li = 0; bytes_sent - rand_start < RANDOM_BYTES; li++) begin
      quiet = ($urandom_range(0, 7) == 0);
      n = $urandom_range(1, 6);
      // back-pressure: long receiver hold-off while files stream in flat out
      if (li == 2 || li == 9) begin
        hold_req++;
        quiet = 1;
        n = 6;
      end
      need_start = 1;
      for (int e = 0; e < n; e++) begin
        kind = (quiet && hold_done < hold_req) ? 0 : $urandom_range(0, 99);
        random_file();
        if (kind < 70) begin
          send_entry(need_start, 32);
          need_start = 0;
        end else if (kind < 78) begin
          entry_bytes[0] = DELETED_MARK;
          send_entry(need_start, 32);
          need_start = 0;
        end else if (kind < 86) begin
          entry_bytes[POS_ATTR] = ATTR_LFN;
          send_entry(need_start, 32);
          need_start = 0;
        end else if (kind < 92) begin
          entry_bytes[POS_ATTR][ATTR_VOL_BIT] = 1'b1;
          send_entry(need_start, 32);
          need_start = 0;
        end else if (kind < 97) begin
          // cut short: the next entry restarts the listing
          send_entry(need_start, $urandom_range(1, 31));
          need_start = 1;
        end else begin
          // raw noise, may even hit an end marker
          for (int i = 0; i < 32; i++) entry_bytes[i] = 8'($urandom_range(0, 255));
          send_entry(need_start, 32);
          need_start = 0;
        end
      end
      if ($urandom_range(0, 99) < 85) begin
        end_marker();
        send_entry(need_start, 32);
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    quiet = 0;

    // drain: wait for every expected word, then a little longer
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d directory bytes in %0d cycles with %0d receiver hold-offs",
             bytes_sent, cycles, hold_done);
    $display("checked %0d entry words and %0d end-of-listing words, %0d mismatches",
             sb.file_words, sb.end_words, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
